[hw/rtl/qcu_pkg.sv]
package qcu_pkg;

   // one raw byte of the container file
   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_file;
   } qcu_req_type;

   typedef enum logic [1:0] {
      ST_DATA      = 2'd0,
      ST_NO_KEY    = 2'd1,
      ST_BAD_SKIP  = 2'd2,
      ST_TRUNCATED = 2'd3
   } qcu_status_type;

   typedef struct packed {
      logic [7:0]     plain_byte;
      logic [7:0]     found_key;
      qcu_status_type status;
      logic           last_result;
   } qcu_rsp_type;

   // front -> back command: raw byte plus what to do with it
   typedef struct packed {
      qcu_status_type status;
      logic [7:0]     raw_byte;
      logic [7:0]     key;
      logic           last;
   } qcu_cmd_type;

   typedef struct packed {
      logic [7:0] header_mask;
      logic [7:0] magic_first_byte;
      logic [7:0] terminator_byte;
   } qcu_cfg_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SCAN,
      PH_SKIP,
      PH_PAYLOAD,
      PH_DRAIN
   } qcu_phase_type;

   typedef enum logic [1:0] {
      CSR_HEADER_MASK = 2'd0,
      CSR_MAGIC       = 2'd1,
      CSR_TERMINATOR  = 2'd2
   } qcu_csr_type;

   localparam int unsigned CSR_ADDR_BITS = 4;

   localparam logic [7:0] HEADER_MASK_RESET = 8'h5A;
   localparam logic [7:0] MAGIC_RESET       = 8'h4D;
   localparam logic [7:0] TERMINATOR_RESET  = 8'h09;

   localparam logic [31:0] ORIG_SIZE_AT = 32'h0000_0D54;
   localparam logic [31:0] META_SIZE_AT = 32'h0000_12A0;
   localparam logic [32:0] META_BASE    = 33'h0_0000_12B8;
   localparam logic [32:0] META_EXTRA   = 33'h0_0000_006D;
   localparam logic [32:0] CONT_BASE    = META_BASE + META_EXTRA;

   localparam logic signed [33:0] SKIP_EXTRA = 34'sd5;

endpackage

[hw/rtl/quarantine_container_unwrap.sv]
// Path: a req beat that yields a result is written to the queue, then loaded into the output
// register, which drives rsp.
// Throughput: one byte per cycle sustained; the front parser takes a byte every cycle
// while the queue has room; the output register drains one beat a cycle on rsp_ready.
// Reset: synchronous, active high; parser back to header collection, queue and output
// emptied, CSRs back to mask 0x5A, magic 0x4D, terminator 0x09. No clearing pass.
module quarantine_container_unwrap #(
   parameter int unsigned POSITION_BITS = 32,
   parameter int unsigned QUEUE_DEPTH   = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // byte stream in
   input  logic                                req_valid,
   output logic                                req_ready,
   input  qcu_pkg::qcu_req_type                req_data,
   // decoded beats out
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output qcu_pkg::qcu_rsp_type                rsp_data,
   // APB-style CSR port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [qcu_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   qcu_pkg::qcu_cfg_type cfg_ff, cfg_in;
   qcu_pkg::qcu_csr_type csr_sel;
   logic                 csr_wr;

   logic                 take;
   logic                 push;
   qcu_pkg::qcu_cmd_type push_cmd;
   logic                 q_full, q_nonempty, q_pop;
   qcu_pkg::qcu_cmd_type q_cmd;

   // --- CSR block: three byte-wide registers at word offsets 0, 4, 8 ---
   assign csr_pready = 1'b1;
   assign csr_sel    = qcu_pkg::qcu_csr_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            qcu_pkg::CSR_HEADER_MASK: cfg_in.header_mask      = csr_pwdata[7:0];
            qcu_pkg::CSR_MAGIC:       cfg_in.magic_first_byte = csr_pwdata[7:0];
            qcu_pkg::CSR_TERMINATOR:  cfg_in.terminator_byte  = csr_pwdata[7:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         qcu_pkg::CSR_HEADER_MASK: csr_prdata = {24'h0, cfg_ff.header_mask};
         qcu_pkg::CSR_MAGIC:       csr_prdata = {24'h0, cfg_ff.magic_first_byte};
         qcu_pkg::CSR_TERMINATOR:  csr_prdata = {24'h0, cfg_ff.terminator_byte};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_mask      <= qcu_pkg::HEADER_MASK_RESET;
         cfg_ff.magic_first_byte <= qcu_pkg::MAGIC_RESET;
         cfg_ff.terminator_byte  <= qcu_pkg::TERMINATOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // --- front: parses header, finds terminator and payload, derives key ---
   // ready only looks at queue room, so a stalled rsp side never stops the
   // parser until the queue actually fills
   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   qcu_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .push     (push),
      .cmd      (push_cmd)
   );

   // --- short queue decoupling parser from the output stage ---
   qcu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (q_full),
      .nonempty  (q_nonempty),
      .pop       (q_pop),
      .pop_data  (q_cmd)
   );

   // --- back: XOR decode, error shaping, output register ---
   qcu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .nonempty  (q_nonempty),
      .cmd       (q_cmd),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/qcu_front.sv]
module qcu_front #(
   parameter int unsigned POSITION_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  qcu_pkg::qcu_req_type req_data,
   input  qcu_pkg::qcu_cfg_type cfg,
   output logic                 push,
   output qcu_pkg::qcu_cmd_type cmd
);

   localparam int unsigned WIDE_BITS = ((POSITION_BITS > 34) ? POSITION_BITS : 34) + 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [POSITION_BITS-3:0] ORIG_WORD =
      (POSITION_BITS-2)'(qcu_pkg::ORIG_SIZE_AT >> 2);
   localparam logic [POSITION_BITS-3:0] META_WORD =
      (POSITION_BITS-2)'(qcu_pkg::META_SIZE_AT >> 2);

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   qcu_pkg::qcu_phase_type   phase_ff, phase_in;
   logic [31:0]              orig_ff, orig_in;
   logic [31:0]              meta_ff, meta_in;
   logic [31:0]              cont_ff, cont_in;
   logic [32:0]              coff_ff, coff_in;
   logic signed [33:0]       skip_ff, skip_in;
   logic [WIDE_BITS-1:0]     start_ff, start_in;
   logic [7:0]               key_ff, key_in;

   logic [7:0]           masked;
   logic [7:0]           cand_key;
   logic [WIDE_BITS-1:0] coff_diff;
   logic                 in_orig, in_meta, in_cont, cont_done;
   logic                 term_hit, skip_ok, start_hit, key_bad, eof;
   logic [4:0]           lane_sh, cont_sh;
   logic                 res_valid;

   assign eof       = req_data.end_of_file;
   assign masked    = req_data.byte_value ^ cfg.header_mask;
   assign cand_key  = req_data.byte_value ^ cfg.magic_first_byte;
   assign in_orig   = pos_ff[POSITION_BITS-1:2] == ORIG_WORD;
   assign in_meta   = pos_ff[POSITION_BITS-1:2] == META_WORD;
   assign lane_sh   = {pos_ff[1:0], 3'b000};
   assign coff_diff = WIDE_BITS'(pos_ff) - WIDE_BITS'(coff_ff);
   assign in_cont   = coff_diff[WIDE_BITS-1:2] == '0;
   assign cont_sh   = {coff_diff[1:0], 3'b000};
   assign cont_done = in_cont && (coff_diff[1:0] == 2'd3);
   assign term_hit  = masked == cfg.terminator_byte;
   assign skip_ok   = !skip_ff[33] && (skip_ff != '0);
   assign start_hit = WIDE_BITS'(pos_ff) == start_ff;
   assign key_bad   = (cand_key == 8'h00) || (cand_key == 8'hFF);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            qcu_pkg::PH_HEADER: begin
               if (cont_done) phase_in = qcu_pkg::PH_SCAN;
            end
            qcu_pkg::PH_SCAN: begin
               if (term_hit) phase_in = skip_ok ? qcu_pkg::PH_SKIP : qcu_pkg::PH_DRAIN;
            end
            qcu_pkg::PH_SKIP: begin
               if (start_hit) phase_in = key_bad ? qcu_pkg::PH_DRAIN : qcu_pkg::PH_PAYLOAD;
            end
            qcu_pkg::PH_PAYLOAD, qcu_pkg::PH_DRAIN: begin
               phase_in = phase_ff;
            end
            default: begin
               phase_in = qcu_pkg::PH_HEADER;
            end
         endcase
         if (eof) phase_in = qcu_pkg::PH_HEADER;
      end
   end

   // command towards the back end
   always_comb begin
      res_valid    = 1'b0;
      cmd.status   = qcu_pkg::ST_DATA;
      cmd.raw_byte = req_data.byte_value;
      cmd.key      = key_ff;
      cmd.last     = eof;
      unique case (phase_ff)
         qcu_pkg::PH_SCAN: begin
            if (term_hit && !skip_ok) begin
               res_valid  = 1'b1;
               cmd.status = qcu_pkg::ST_BAD_SKIP;
            end
         end
         qcu_pkg::PH_SKIP: begin
            if (start_hit) begin
               res_valid  = 1'b1;
               cmd.key    = cand_key;
               cmd.status = key_bad ? qcu_pkg::ST_NO_KEY : qcu_pkg::ST_DATA;
            end
         end
         qcu_pkg::PH_PAYLOAD: begin
            res_valid = 1'b1;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
      if (eof && !res_valid && (phase_ff == qcu_pkg::PH_HEADER ||
                                phase_ff == qcu_pkg::PH_SCAN ||
                                phase_ff == qcu_pkg::PH_SKIP)) begin
         res_valid  = 1'b1;
         cmd.status = qcu_pkg::ST_TRUNCATED;
      end
      push = take && res_valid;
   end

   // header capture and position tracking
   always_comb begin
      pos_in   = pos_ff;
      orig_in  = orig_ff;
      meta_in  = meta_ff;
      cont_in  = cont_ff;
      skip_in  = skip_ff;
      start_in = start_ff;
      key_in   = key_ff;
      if (take) begin
         if (phase_ff == qcu_pkg::PH_HEADER) begin
            if (in_orig) orig_in = orig_ff | (32'(req_data.byte_value) << lane_sh);
            if (in_meta) meta_in = meta_ff | (32'(masked) << lane_sh);
            if (in_cont) cont_in = cont_ff | (32'(masked) << cont_sh);
            if (cont_done) begin
               skip_in = $signed({2'b00, cont_in}) - $signed({2'b00, orig_ff})
                         + qcu_pkg::SKIP_EXTRA;
            end
         end
         if (phase_ff == qcu_pkg::PH_SCAN && term_hit && skip_ok) begin
            start_in = WIDE_BITS'(pos_ff) + WIDE_BITS'(skip_ff[32:0]);
         end
         if (phase_ff == qcu_pkg::PH_SKIP && start_hit && !key_bad) key_in = cand_key;
         pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
         if (eof) begin
            pos_in   = '0;
            orig_in  = '0;
            meta_in  = '0;
            cont_in  = '0;
            skip_in  = '0;
            start_in = '0;
            key_in   = '0;
         end
      end
      coff_in = qcu_pkg::CONT_BASE + 33'(meta_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= qcu_pkg::PH_HEADER;
         pos_ff   <= '0;
         orig_ff  <= '0;
         meta_ff  <= '0;
         cont_ff  <= '0;
         coff_ff  <= qcu_pkg::CONT_BASE;
         skip_ff  <= '0;
         start_ff <= '0;
         key_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         orig_ff  <= orig_in;
         meta_ff  <= meta_in;
         cont_ff  <= cont_in;
         coff_ff  <= coff_in;
         skip_ff  <= skip_in;
         start_ff <= start_in;
         key_ff   <= key_in;
      end
   end

   a_payload_key_usable: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == qcu_pkg::PH_PAYLOAD) |-> (key_ff != 8'h00 && key_ff != 8'hFF))
      else $error("payload phase with unusable key");

   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      (take && eof) |=> (pos_ff == '0 && phase_ff == qcu_pkg::PH_HEADER))
      else $error("end of file did not restart parser");

endmodule

[hw/rtl/qcu_queue.sv]
module qcu_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qcu_pkg::qcu_cmd_type push_data,
   output logic                 full,
   output logic                 nonempty,
   input  logic                 pop,
   output qcu_pkg::qcu_cmd_type pop_data
);

   localparam int unsigned PTR_BITS = $clog2(DEPTH);
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   qcu_pkg::qcu_cmd_type ent_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   assign full     = count_ff == FULL_CNT;
   assign nonempty = count_ff != '0;
   assign pop_data = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue fill count beyond depth");

endmodule

[hw/rtl/qcu_back.sv]
module qcu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 nonempty,
   input  qcu_pkg::qcu_cmd_type cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qcu_pkg::qcu_rsp_type rsp_data
);

   logic                 rsp_valid_ff, rsp_valid_in;
   qcu_pkg::qcu_rsp_type rsp_data_ff, rsp_data_in;
   qcu_pkg::qcu_rsp_type fmt;
   logic                 load;

   assign load = nonempty && (!rsp_valid_ff || rsp_ready);
   assign pop  = load;

   // errors carry zeroed byte and key and always close the stream
   always_comb begin
      fmt.status = cmd.status;
      if (cmd.status == qcu_pkg::ST_DATA) begin
         fmt.plain_byte  = cmd.raw_byte ^ cmd.key;
         fmt.found_key   = cmd.key;
         fmt.last_result = cmd.last;
      end else begin
         fmt.plain_byte  = '0;
         fmt.found_key   = '0;
         fmt.last_result = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fmt;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_error_beat_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != qcu_pkg::ST_DATA) |->
      (rsp_data_ff.last_result && rsp_data_ff.plain_byte == '0 &&
       rsp_data_ff.found_key == '0))
      else $error("error beat not zeroed or not last");

endmodule
